// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ADS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ADS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ads_pkg.sv =====
`default_nettype none
package ads_pkg;

   localparam int MAX_WIDTH_DEFAULT = 1024;

   localparam int PIX_W       = 20;
   localparam int COEF_W      = 16;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 16;
   localparam int TSTEP_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int HADDR_MAX_W = 16;   // history address width at the largest MAX_WIDTH
   localparam int COEF3_W     = 3 * COEF_W;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1024;
   localparam logic [TSTEP_W-1:0]  TSTEP_RESET  = 16'd16384;

   localparam logic signed [COEF_W-1:0] ONE_Q12  = 16'sd4096;
   localparam logic signed [COEF_W-1:0] ZERO_Q12 = 16'sd0;
   localparam logic signed [PIX_W-1:0]  PIX_MAX  = 20'sh7FFFF;
   localparam logic signed [PIX_W-1:0]  PIX_MIN  = 20'sh80000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_TIME_STEP    = 2'd2,
      CSR_USE_COEF     = 2'd3
   } csr_idx_type;

   // one output position handed from the front to the back
   typedef struct packed {
      logic [WIDTH_W-1:0]     col;
      logic [HADDR_MAX_W-1:0] base;    // history address of column 0 of this row
      logic                   top;
      logic                   bottom;
      logic                   left;
      logic                   right;
      logic                   last;
   } job_type;

   function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] raw,
                                                     input int max_w);
      logic [WIDTH_W-1:0] r;
      if (raw == '0) begin
         r = WIDTH_W'(1);
      end else if (32'(raw) > max_w) begin
         r = WIDTH_W'(max_w);
      end else begin
         r = raw;
      end
      return r;
   endfunction

   function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] raw);
      return (raw == '0) ? HEIGHT_W'(1) : raw;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ads_if.sv =====
`default_nettype none
interface ads_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    op;
   logic signed [ads_pkg::PIX_W-1:0]        pixel_in;
   logic signed [ads_pkg::COEF_W-1:0]       coef_a;
   logic signed [ads_pkg::COEF_W-1:0]       coef_b;
   logic signed [ads_pkg::COEF_W-1:0]       coef_c;
   modport source (output valid, op, pixel_in, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, op, pixel_in, coef_a, coef_b, coef_c, output ready);
endinterface

interface ads_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [ads_pkg::PIX_W-1:0]        pixel_out;
   logic                                    frame_last;
   modport source (output valid, pixel_out, frame_last, input ready);
   modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/ads_ram.sv =====
`default_nettype none
module ads_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/ads_front.sv =====
`default_nettype none
module ads_front #(
   parameter int MAX_WIDTH = ads_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ads_req_if.sink                                  req,
   input  wire logic [ads_pkg::WIDTH_W-1:0]         width_reg,
   input  wire logic [ads_pkg::HEIGHT_W-1:0]        height_reg,
   input  wire logic                                use_coef,
   input  wire logic                                restart,
   output logic                                     hist_we,
   output logic [$clog2(MAX_WIDTH)+2:0]             hist_waddr,
   output logic [ads_pkg::PIX_W-1:0]                hist_wdata,
   output logic                                     coef_we,
   output logic [$clog2(MAX_WIDTH)+1:0]             coef_waddr,
   output logic [ads_pkg::COEF3_W-1:0]              coef_wdata,
   output logic                                     job_valid,
   output ads_pkg::job_type                         job,
   input  wire logic                                job_ready
);
   localparam int HAW    = $clog2(MAX_WIDTH) + 3;
   localparam int CAW    = $clog2(MAX_WIDTH) + 2;
   localparam int WW     = ads_pkg::WIDTH_W;
   localparam int HW     = ads_pkg::HEIGHT_W;
   localparam int LEAD_W = WW + 1;

   logic [WW-1:0]     col_ff, col_in, ocol_ff, ocol_in;
   logic [HW-1:0]     row_ff, row_in, orow_ff, orow_in;
   logic [HAW-1:0]    p_ff, p_in, base_ff, base_in;
   logic [LEAD_W-1:0] lead_ff, lead_in, lead_full;
   logic [WW-1:0]     w;
   logic [HW-1:0]     h;
   logic              take, in_frame, counted, emit, last;

   assign w         = ads_pkg::eff_width(width_reg, MAX_WIDTH);
   assign h         = ads_pkg::eff_height(height_reg);
   assign lead_full = {1'b0, w} + LEAD_W'(1);

   assign req.ready = job_ready;
   assign take      = req.valid && job_ready;
   assign in_frame  = row_ff < h;
   // an early drain changes nothing
   assign counted   = take && !(in_frame && req.op);
   assign emit      = counted && (lead_ff == lead_full);
   assign last      = (orow_ff == h - HW'(1)) && (ocol_ff == w - WW'(1));

   assign hist_we    = counted && in_frame;
   assign hist_waddr = p_ff;
   assign hist_wdata = req.pixel_in;
   assign coef_we    = counted && in_frame;
   assign coef_waddr = p_ff[CAW-1:0];
   assign coef_wdata = use_coef ? {req.coef_a, req.coef_b, req.coef_c}
                                : {ads_pkg::ONE_Q12, ads_pkg::ZERO_Q12, ads_pkg::ONE_Q12};

   assign job_valid  = emit;
   assign job.col    = ocol_ff;
   assign job.base   = ads_pkg::HADDR_MAX_W'(base_ff);
   assign job.top    = (orow_ff == '0);
   assign job.bottom = (orow_ff == h - HW'(1));
   assign job.left   = (ocol_ff == '0);
   assign job.right  = (ocol_ff == w - WW'(1));
   assign job.last   = last;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      p_in    = p_ff;
      lead_in = lead_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      base_in = base_ff;
      if (counted) begin
         p_in = p_ff + HAW'(1);
         if (lead_ff != lead_full) begin
            lead_in = lead_ff + LEAD_W'(1);
         end
         if (in_frame) begin
            if (col_ff == w - WW'(1)) begin
               col_in = '0;
               row_in = row_ff + HW'(1);
            end else begin
               col_in = col_ff + WW'(1);
            end
         end
      end
      if (emit) begin
         if (ocol_ff == w - WW'(1)) begin
            ocol_in = '0;
            orow_in = orow_ff + HW'(1);
            base_in = base_ff + HAW'(w);
         end else begin
            ocol_in = ocol_ff + WW'(1);
         end
      end
      // new frame starts at the next history address, so jobs of the old
      // frame still in flight keep reading their own entries
      if ((emit && last) || restart) begin
         col_in  = '0;
         row_in  = '0;
         lead_in = '0;
         ocol_in = '0;
         orow_in = '0;
         base_in = p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         p_ff    <= '0;
         lead_ff <= '0;
         ocol_ff <= '0;
         orow_ff <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         p_ff    <= p_in;
         lead_ff <= lead_in;
         ocol_ff <= ocol_in;
         orow_ff <= orow_in;
         base_ff <= base_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/ads_queue.sv =====
`default_nettype none
module ads_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire ads_pkg::job_type  push_data,
   output logic                   push_ready,
   output logic                   pop_valid,
   output ads_pkg::job_type       pop_data,
   input  wire logic              pop_ready
);
   ads_pkg::job_type entry_ff [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_data   = entry_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/ads_back.sv =====
`default_nettype none
module ads_back #(
   parameter int MAX_WIDTH = ads_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            job_valid,
   input  wire ads_pkg::job_type                job,
   output logic                                 job_pop,
   input  wire logic [ads_pkg::WIDTH_W-1:0]     width_reg,
   input  wire logic [ads_pkg::TSTEP_W-1:0]     tstep_reg,
   output logic [$clog2(MAX_WIDTH)+2:0]         hist_raddr,
   input  wire logic [ads_pkg::PIX_W-1:0]       hist_rdata,
   output logic [$clog2(MAX_WIDTH)+1:0]         coef_raddr,
   input  wire logic [ads_pkg::COEF3_W-1:0]     coef_rdata,
   ads_rsp_if.source                            rsp
);
   localparam int HAW = $clog2(MAX_WIDTH) + 3;
   localparam int CAW = $clog2(MAX_WIDTH) + 2;
   localparam int WW  = ads_pkg::WIDTH_W;
   localparam int PW  = ads_pkg::PIX_W;
   localparam int CW  = ads_pkg::COEF_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_TAIL = 7'b0000100,
      S_SUM  = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_TMUL = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   ads_pkg::job_type        job_ff;
   logic [3:0]              k_ff, k_in;
   logic [1:0]              dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PW-1:0]    win_ff [9];
   logic [ads_pkg::COEF3_W-1:0] coef_ff;
   logic signed [21:0]      d_ff, e_ff, f_ff;
   logic signed [16:0]      g_ff;
   logic signed [40:0]      acc_ff;
   logic signed [56:0]      tacc_ff;
   logic                    valid_ff, valid_in;
   logic signed [PW-1:0]    pix_ff;
   logic                    last_ff;

   logic [WW-1:0]           w, colv;
   logic [HAW-1:0]          base, rowb, qaddr;
   logic                    capture;
   logic signed [CW-1:0]    ca, cb, cc;
   logic signed [16:0]      mul_a;
   logic signed [21:0]      mul_b;
   logic signed [38:0]      mul_p;
   logic signed [40:0]      term;
   logic signed [8:0]       tbyte;
   logic signed [49:0]      tprod;
   logic signed [25:0]      delta;
   logic signed [26:0]      ysum;
   logic signed [PW-1:0]    ysat;
   logic                    out_free;

   assign w    = ads_pkg::eff_width(width_reg, MAX_WIDTH);
   assign base = job_ff.base[HAW-1:0];
   assign ca   = coef_ff[3*CW-1:2*CW];
   assign cb   = coef_ff[2*CW-1:CW];
   assign cc   = coef_ff[CW-1:0];

   // neighbor address: clamped row base plus clamped column
   always_comb begin
      case (dx_ff)
         2'd0:    colv = job_ff.left ? job_ff.col : job_ff.col - WW'(1);
         2'd1:    colv = job_ff.col;
         default: colv = job_ff.right ? job_ff.col : job_ff.col + WW'(1);
      endcase
      case (dy_ff)
         2'd0:    rowb = job_ff.top ? base : base - HAW'(w);
         2'd1:    rowb = base;
         default: rowb = job_ff.bottom ? base : base + HAW'(w);
      endcase
   end
   assign hist_raddr = rowb + HAW'(colv);
   assign qaddr      = base + HAW'(job_ff.col);
   assign coef_raddr = qaddr[CAW-1:0];

   assign capture = ((state_ff == S_READ) && (k_ff != 4'd0)) || (state_ff == S_TAIL);

   // stencil products, one per cycle
   always_comb begin
      case (k_ff[1:0])
         2'd0:    begin mul_a = 17'(cb); mul_b = d_ff; end
         2'd1:    begin mul_a = 17'(cc); mul_b = e_ff; end
         2'd2:    begin mul_a = 17'(ca); mul_b = f_ff; end
         default: begin mul_a = g_ff;    mul_b = 22'(win_ff[4]); end
      endcase
   end
   assign mul_p = 39'(mul_a) * 39'(mul_b);
   always_comb begin
      case (k_ff[1:0])
         2'd0:    term = 41'(mul_p);
         2'd1,
         2'd2:    term = 41'(mul_p) <<< 1;
         default: term = -(41'(mul_p) <<< 2);
      endcase
   end

   // S * t in two byte-wide partial products
   assign tbyte = $signed({1'b0, (k_ff[0] ? tstep_reg[15:8] : tstep_reg[7:0])});
   assign tprod = 50'(acc_ff) * 50'(tbyte);

   assign delta = $signed(tacc_ff[56:31]);
   assign ysum  = 27'(win_ff[4]) + 27'(delta);
   always_comb begin
      if (ysum > 27'(ads_pkg::PIX_MAX)) begin
         ysat = ads_pkg::PIX_MAX;
      end else if (ysum < 27'(ads_pkg::PIX_MIN)) begin
         ysat = ads_pkg::PIX_MIN;
      end else begin
         ysat = PW'(ysum);
      end
   end

   assign out_free       = !valid_ff || rsp.ready;
   assign rsp.valid      = valid_ff;
   assign rsp.pixel_out  = pix_ff;
   assign rsp.frame_last = last_ff;
   assign job_pop        = (state_ff == S_IDLE) && job_valid;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      valid_in = valid_ff && !rsp.ready;
      unique case (state_ff)
         S_IDLE: begin
            k_in  = '0;
            dx_in = '0;
            dy_in = '0;
            if (job_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            k_in = k_ff + 4'd1;
            if (dx_ff == 2'd2) begin
               dx_in = '0;
               dy_in = dy_ff + 2'd1;
            end else begin
               dx_in = dx_ff + 2'd1;
            end
            if (k_ff == 4'd8) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: state_in = S_SUM;
         S_SUM: begin
            k_in     = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd3) begin
               k_in     = '0;
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd1) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
      end
      if (capture) begin
         for (int i = 0; i < 8; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[8] <= $signed(hist_rdata);
      end
      if ((state_ff == S_READ) && (k_ff == 4'd1)) begin
         coef_ff <= coef_rdata;
      end
      if (state_ff == S_SUM) begin
         d_ff   <= 22'(win_ff[0]) - 22'(win_ff[2]) - 22'(win_ff[6]) + 22'(win_ff[8]);
         e_ff   <= 22'(win_ff[1]) + 22'(win_ff[7]);
         f_ff   <= 22'(win_ff[3]) + 22'(win_ff[5]);
         g_ff   <= 17'(ca) + 17'(cc);
         acc_ff <= '0;
      end
      if (state_ff == S_MUL) begin
         acc_ff <= acc_ff + term;
      end
      if (state_ff == S_TMUL) begin
         if (k_ff[0]) begin
            tacc_ff <= tacc_ff + (57'(tprod) <<< 8);
         end else begin
            tacc_ff <= 57'(tprod) + (57'sd1 <<< 30);
         end
      end
      if ((state_ff == S_OUT) && out_free) begin
         pix_ff  <= ysat;
         last_ff <= job_ff.last;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         dx_ff    <= '0;
         dy_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         valid_ff <= valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/anisotropic_diffusion_step_top.sv =====
// One explicit anisotropic diffusion step over a raster-order pixel stream.
// req_ch carries one item per transfer: op (0 pixel, 1 drain), pixel_in and
// the pixel's (a,b,c) matrix. rsp_ch carries pixel_out and frame_last.
// csr_we/csr_idx/csr_wdata write image_width, image_height, time_step and
// use_coef_field; write them only while the block is idle.
// The result for position q is computed once the item at q+W+1 is taken:
// its job passes the job queue, is popped when the engine is free and runs
// through the compute engine. Send W+1 drain items after the frame to flush it.
// Throughput: the front takes one item per cycle while its two-entry job
// queue has room; the engine works on one job at a time (job pop, nine
// single-port history reads plus one read tail, window sums, four stencil
// products on one multiplier, two partial products for the time step, output
// load) and pops the next job only after the output load.
// Reset: counters clear, registers return to W=H=1024, t=0.25, default
// matrix. The line stores need no clearing.
// Receiver stall: the result holds in the output register; the engine waits,
// the queue fills and then req_ch.ready drops.
`default_nettype none
module anisotropic_diffusion_step_top #(
   parameter int MAX_WIDTH = ads_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ads_req_if.sink                                req_ch,
   ads_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [ads_pkg::CSR_IDX_W-1:0]     csr_idx,
   input  wire logic [ads_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   // history store spans 8*MAX_WIDTH positions, coefficients 4*MAX_WIDTH;
   // both leave slack for the queue lag between write and read
   localparam int HAW = $clog2(MAX_WIDTH) + 3;
   localparam int CAW = $clog2(MAX_WIDTH) + 2;

   logic [ads_pkg::WIDTH_W-1:0]  width_ff;
   logic [ads_pkg::HEIGHT_W-1:0] height_ff;
   logic [ads_pkg::TSTEP_W-1:0]  tstep_ff;
   logic                         use_coef_ff;
   logic                         restart;

   logic                         hist_we, coef_we;
   logic [HAW-1:0]               hist_waddr, hist_raddr;
   logic [ads_pkg::PIX_W-1:0]    hist_wdata, hist_rdata;
   logic [CAW-1:0]               coef_waddr, coef_raddr;
   logic [ads_pkg::COEF3_W-1:0]  coef_wdata, coef_rdata;

   logic                         fj_valid, fj_ready, bj_valid, bj_pop;
   ads_pkg::job_type             fj_data, bj_data;

   // writes to either size register abandon the current frame
   assign restart = csr_we && ((csr_idx == ads_pkg::CSR_IMAGE_WIDTH) ||
                               (csr_idx == ads_pkg::CSR_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= ads_pkg::WIDTH_RESET;
         height_ff   <= ads_pkg::HEIGHT_RESET;
         tstep_ff    <= ads_pkg::TSTEP_RESET;
         use_coef_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_idx)
            ads_pkg::CSR_IMAGE_WIDTH:  width_ff    <= csr_wdata[ads_pkg::WIDTH_W-1:0];
            ads_pkg::CSR_IMAGE_HEIGHT: height_ff   <= csr_wdata;
            ads_pkg::CSR_TIME_STEP:    tstep_ff    <= csr_wdata;
            ads_pkg::CSR_USE_COEF:     use_coef_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ads_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .width_reg  (width_ff),
      .height_reg (height_ff),
      .use_coef   (use_coef_ff),
      .restart    (restart),
      .hist_we    (hist_we),
      .hist_waddr (hist_waddr),
      .hist_wdata (hist_wdata),
      .coef_we    (coef_we),
      .coef_waddr (coef_waddr),
      .coef_wdata (coef_wdata),
      .job_valid  (fj_valid),
      .job        (fj_data),
      .job_ready  (fj_ready)
   );

   ads_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_data  (fj_data),
      .push_ready (fj_ready),
      .pop_valid  (bj_valid),
      .pop_data   (bj_data),
      .pop_ready  (bj_pop)
   );

   ads_ram #(.WIDTH(ads_pkg::PIX_W), .DEPTH(2**HAW)) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   ads_ram #(.WIDTH(ads_pkg::COEF3_W), .DEPTH(2**CAW)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (coef_waddr),
      .wdata (coef_wdata),
      .raddr (coef_raddr),
      .rdata (coef_rdata)
   );

   ads_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (bj_valid),
      .job        (bj_data),
      .job_pop    (bj_pop),
      .width_reg  (width_ff),
      .tstep_reg  (tstep_ff),
      .hist_raddr (hist_raddr),
      .hist_rdata (hist_rdata),
      .coef_raddr (coef_raddr),
      .coef_rdata (coef_rdata),
      .rsp        (rsp_ch)
   );
endmodule
`default_nettype wire

// ===== rtl/ads_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module ads_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [ads_pkg::PIX_W-1:0]    rsp_pixel_out,
   input wire logic                         rsp_frame_last
);
   // stalled result holds
   `ADS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_frame_last))
   // a shown result carries known data
   `ADS_ASSERT_IMP(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_pixel_out) && !$isunknown(rsp_frame_last))
   // nothing is shown right after reset
   `ADS_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid)
endmodule

bind anisotropic_diffusion_step_top ads_checker u_ads_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pixel_out  (rsp_ch.pixel_out),
   .rsp_frame_last (rsp_ch.frame_last)
);
`default_nettype wire

// ===== dv/anisotropic_diffusion_step_top_test.sv =====
`default_nettype none
module anisotropic_diffusion_step_top_test;

   // sizes for the shadow of the block under test, at its default MAX_WIDTH
   localparam int MAX_W      = ads_pkg::MAX_WIDTH_DEFAULT;
   localparam int HIST_DEPTH = 2 * MAX_W + 3;
   localparam int COEF_DEPTH = MAX_W + 1;
   localparam int SETTLE     = 60;
   localparam int CYCLE_MAX  = 1_000_000;
   localparam int ITEM_GOAL  = 1100;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic signed [ads_pkg::PIX_W-1:0] pixel;
      logic                             last;
   } diffused_pixel_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [ads_pkg::CSR_IDX_W-1:0]  csr_idx;
   logic [ads_pkg::CSR_DATA_W-1:0] csr_wdata;

   ads_req_if req ();
   ads_rsp_if rsp ();

   anisotropic_diffusion_step_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Shadow of the block: registers, line stores and frame position
   // ---------------------------------------------------------------------------
   int unsigned shadow_width, shadow_height, shadow_tstep;
   bit          shadow_use_coef;
   longint      pix_hist [HIST_DEPTH];
   longint      coef_hist [COEF_DEPTH][3];
   int unsigned col_pos, row_pos, drain_pos;

   diffused_pixel_type pending_pixels[$];   // expected results, oldest first
   int  mismatches;
   int  items_sent;
   int  cycles;
   bit  quiet;                              // no idling on either side

   function automatic int unsigned frame_width();
      if (shadow_width == 0) return 1;
      if (shadow_width > MAX_W) return MAX_W;
      return shadow_width;
   endfunction

   function automatic int unsigned frame_height();
      return (shadow_height == 0) ? 1 : shadow_height;
   endfunction

   function automatic void restart_frame();
      col_pos   = 0;
      row_pos   = 0;
      drain_pos = 0;
   endfunction

   function automatic void shadow_csr_write(ads_pkg::csr_idx_type idx,
                                            logic [ads_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         ads_pkg::CSR_IMAGE_WIDTH: begin
            shadow_width = data[ads_pkg::WIDTH_W-1:0];
            restart_frame();
         end
         ads_pkg::CSR_IMAGE_HEIGHT: begin
            shadow_height = data;
            restart_frame();
         end
         ads_pkg::CSR_TIME_STEP:    shadow_tstep = data;
         ads_pkg::CSR_USE_COEF:     shadow_use_coef = data[0];
         default: ;
      endcase
   endfunction

   // Advance the shadow by one transfer; queue the diffused pixel it releases.
   // Returns 0 when the block ignores the item (a drain while pixels are due).
   function automatic bit diffuse_item(logic op, logic signed [ads_pkg::PIX_W-1:0] pix,
                                       logic signed [ads_pkg::COEF_W-1:0] ca,
                                       logic signed [ads_pkg::COEF_W-1:0] cb,
                                       logic signed [ads_pkg::COEF_W-1:0] cc);
      int unsigned w, h, pos, q, n;
      int          ci, ri, xi, yi;
      longint      nb [9];
      longint      ka, kb, kc, s, delta, y;
      diffused_pixel_type res;
      w   = frame_width();
      h   = frame_height();
      pos = row_pos * w + col_pos + drain_pos;
      if (row_pos < h) begin
         if (op == OP_DRAIN) return 0;
         pix_hist[pos % HIST_DEPTH] = pix;
         if (shadow_use_coef) begin
            coef_hist[pos % COEF_DEPTH][0] = ca;
            coef_hist[pos % COEF_DEPTH][1] = cb;
            coef_hist[pos % COEF_DEPTH][2] = cc;
         end else begin
            coef_hist[pos % COEF_DEPTH][0] = 4096;
            coef_hist[pos % COEF_DEPTH][1] = 0;
            coef_hist[pos % COEF_DEPTH][2] = 4096;
         end
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
      end else begin
         drain_pos++;          // drains and surplus pixels both land here
      end
      if (pos < w + 1) return 1;
      q  = pos - (w + 1);
      ci = int'(q % w);
      ri = int'(q / w);
      // 3x3 neighborhood, edges replicated
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            xi = ci + dx;
            yi = ri + dy;
            if (xi < 0) xi = 0;
            if (xi > int'(w) - 1) xi = int'(w) - 1;
            if (yi < 0) yi = 0;
            if (yi > int'(h) - 1) yi = int'(h) - 1;
            n = yi * w + xi;
            nb[(dy + 1) * 3 + dx + 1] = pix_hist[n % HIST_DEPTH];
         end
      end
      ka = coef_hist[q % COEF_DEPTH][0];
      kb = coef_hist[q % COEF_DEPTH][1];
      kc = coef_hist[q % COEF_DEPTH][2];
      s  = kb * (nb[0] - nb[2] - nb[6] + nb[8])
         + 2 * (kc * (nb[1] + nb[7]) + ka * (nb[3] + nb[5]))
         - 4 * (ka + kc) * nb[4];
      // round half up, floor by 2^31
      delta = (s * longint'(shadow_tstep) + (64'sd1 <<< 30)) >>> 31;
      y = nb[4] + delta;
      if (y > 524287) y = 524287;
      if (y < -524288) y = -524288;
      res.pixel = y[ads_pkg::PIX_W-1:0];
      res.last  = (q == w * h - 1);
      pending_pixels.push_back(res);
      if (res.last) restart_frame();
      return 1;
   endfunction

   // ---------------------------------------------------------------------------
   // Clock, cycle limit
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ---------------------------------------------------------------------------
   int stall_left;

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp.ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready  <= 1'b1;
         stall_left <= ($urandom_range(3) == 0) ? pick_gap() : 0;
      end
   end

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      diffused_pixel_type exp_px;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer pixel_out=%0d", rsp.pixel_out));
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp.pixel_out !== exp_px.pixel)
               report_mismatch($sformatf("pixel_out %0d, expected %0d",
                                         rsp.pixel_out, exp_px.pixel));
            if (rsp.frame_last !== exp_px.last)
               report_mismatch($sformatf("frame_last %0b, expected %0b",
                                         rsp.frame_last, exp_px.last));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side; every task starts and ends just after a rising edge
   // ---------------------------------------------------------------------------
   task automatic send_item(logic op, logic signed [ads_pkg::PIX_W-1:0] pix,
                            logic signed [ads_pkg::COEF_W-1:0] ca,
                            logic signed [ads_pkg::COEF_W-1:0] cb,
                            logic signed [ads_pkg::COEF_W-1:0] cc);
      int gap;
      req.valid    <= 1'b1;
      req.op       <= op;
      req.pixel_in <= pix;
      req.coef_a   <= ca;
      req.coef_b   <= cb;
      req.coef_c   <= cc;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (diffuse_item(op, pix, ca, cb, cc)) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random content: full range mostly, extremes and small values now and then
   function automatic logic signed [ads_pkg::PIX_W-1:0] rand_pixel();
      case ($urandom_range(3))
         0:       return $urandom_range(1) ? ads_pkg::PIX_MAX : ads_pkg::PIX_MIN;
         1:       return ads_pkg::PIX_W'($urandom_range(4096)) - ads_pkg::PIX_W'(2048);
         default: return ads_pkg::PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [ads_pkg::COEF_W-1:0] rand_coef();
      case ($urandom_range(3))
         0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1:       return ads_pkg::COEF_W'($urandom_range(8192));
         default: return ads_pkg::COEF_W'($urandom);
      endcase
   endfunction

   task automatic send_random(logic op);
      send_item(op, rand_pixel(), rand_coef(), rand_coef(), rand_coef());
   endtask

   task automatic write_csr(ads_pkg::csr_idx_type idx, logic [ads_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      @(posedge clock);
      shadow_csr_write(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // every expected result has arrived and the engine has nothing in flight
   task automatic wait_idle();
      req.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_frame(int w, int h, int t, bit use_coef);
      write_csr(ads_pkg::CSR_IMAGE_WIDTH, ads_pkg::CSR_DATA_W'(w));
      write_csr(ads_pkg::CSR_IMAGE_HEIGHT, ads_pkg::CSR_DATA_W'(h));
      write_csr(ads_pkg::CSR_TIME_STEP, ads_pkg::CSR_DATA_W'(t));
      write_csr(ads_pkg::CSR_USE_COEF, ads_pkg::CSR_DATA_W'(use_coef));
   endtask

   // whole frame of random pixels with optional early drains, then the flush
   task automatic send_frame(int surplus_pct, int noise_pct);
      int w, h;
      w = frame_width();
      h = frame_height();
      for (int i = 0; i < w * h; i++) begin
         if ($urandom_range(99) < noise_pct) send_random(OP_DRAIN);   // early drain
         send_random(OP_PIXEL);
      end
      for (int i = 0; i <= w; i++)
         send_random(($urandom_range(99) < surplus_pct) ? OP_PIXEL : OP_DRAIN);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // reset values of time step and matrix select stay in force
   task automatic test_reset_defaults();
      write_csr(ads_pkg::CSR_IMAGE_WIDTH, 16'd3);
      write_csr(ads_pkg::CSR_IMAGE_HEIGHT, 16'd2);
      send_frame(0, 0);
      wait_idle();
   endtask

   // saturation at both rails, extreme coefficients, early drain, surplus pixel
   task automatic test_directed_extremes();
      set_frame(3, 3, 65535, 1'b1);
      send_item(OP_DRAIN, ads_pkg::PIX_MAX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);   // ignored
      send_item(OP_PIXEL, ads_pkg::PIX_MAX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_item(OP_PIXEL, ads_pkg::PIX_MIN, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(OP_PIXEL, ads_pkg::PIX_MAX, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_item(OP_PIXEL, ads_pkg::PIX_MIN, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_item(OP_PIXEL, 20'sd0, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(OP_PIXEL, ads_pkg::PIX_MAX, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      send_item(OP_DRAIN, 20'sd0, 16'sd0, 16'sd0, 16'sd0);                      // ignored
      send_item(OP_PIXEL, ads_pkg::PIX_MIN, 16'sd0, 16'sh7FFF, 16'sd0);
      send_item(OP_PIXEL, -20'sd1, 16'sd4096, 16'sd0, 16'sd4096);
      send_item(OP_PIXEL, ads_pkg::PIX_MAX, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(OP_PIXEL, 20'sd5, 16'sd1, 16'sd2, 16'sd3);                      // surplus
      send_item(OP_DRAIN, 20'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_item(OP_DRAIN, ads_pkg::PIX_MIN, 16'sh8000, 16'sh8000, 16'sh8000);
      send_item(OP_DRAIN, 20'sd0, 16'sd0, 16'sd0, 16'sd0);
      wait_idle();
      // zero time step: output equals the center pixel
      set_frame(2, 1, 0, 1'b1);
      send_frame(50, 0);
      wait_idle();
   endtask

   // zero size registers, the tallest frame abandoned, widest row up to its
   // first results
   task automatic test_size_edges();
      set_frame(0, 0, 40000, 1'b1);
      send_frame(0, 0);
      wait_idle();
      write_csr(ads_pkg::CSR_IMAGE_WIDTH, 16'd1);
      write_csr(ads_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      repeat (6) send_random(OP_PIXEL);
      wait_idle();
      write_csr(ads_pkg::CSR_IMAGE_WIDTH, 16'd2047);   // acts as the maximum width
      write_csr(ads_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      repeat (MAX_W) send_random(OP_PIXEL);
      repeat (3) send_random(OP_DRAIN);
      wait_idle();
      // partial frame dropped by a size write, then a clean frame
      set_frame(4, 3, 30000, 1'b0);
      repeat (7) send_random(OP_PIXEL);
      wait_idle();
      write_csr(ads_pkg::CSR_IMAGE_WIDTH, 16'd4);
      send_frame(0, 0);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int w, h, t;
      while (items_sent < ITEM_GOAL) begin
         quiet = ($urandom_range(3) == 0);
         w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         h = $urandom_range(6, 1);
         case ($urandom_range(5))
            0:       t = 0;
            1:       t = 65535;
            default: t = $urandom_range(65535);
         endcase
         set_frame(w, h, t, $urandom_range(3) != 0);
         send_frame(20, 5);
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_idx    = '0;
      csr_wdata  = '0;
      req.valid  = 1'b0;
      req.op     = 1'b0;
      req.pixel_in = '0;
      req.coef_a = '0;
      req.coef_b = '0;
      req.coef_c = '0;
      rsp.ready  = 1'b0;
      stall_left = 0;
      mismatches = 0;
      items_sent = 0;
      cycles     = 0;
      quiet      = 1'b0;
      shadow_width    = 1024;
      shadow_height   = 1024;
      shadow_tstep    = 16384;
      shadow_use_coef = 1'b0;
      restart_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_extremes();
      test_size_edges();
      test_random_frames();

      wait_idle();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
